>>> hdl/dpwp_pkg.sv
package dpwp_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRINCIPAL_X = 3'd0,
    REG_PRINCIPAL_Y = 3'd1,
    REG_INV_FOCAL_X = 3'd2,
    REG_INV_FOCAL_Y = 3'd3,
    REG_INV_DEPTH   = 3'd4,
    REG_QUATERNION  = 3'd5,
    REG_TRANSLATION = 3'd6
  } cfg_reg_e;

  // Camera-space point handed from the front part to the back part.
  typedef struct packed {
    logic signed [37:0] cam_x;
    logic signed [37:0] cam_y;
    logic signed [37:0] cam_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } cam_item_t;

  // Rotation matrix in Q.20 and translation in Q10.10. A quaternion that is
  // not unit length can push matrix entries up to about 2^24 in Q.20.
  typedef struct packed {
    logic signed [8:0][25:0] m;
    logic signed [2:0][20:0] t;
  } pose_t;

  localparam logic [15:0] PrincipalXRst = 16'd5208;
  localparam logic [15:0] PrincipalYRst = 16'd4056;
  localparam logic [23:0] InvFocalXRst  = 24'd32389;
  localparam logic [23:0] InvFocalYRst  = 24'd32326;
  localparam logic [23:0] InvDepthRst   = 24'd16777;
  localparam logic [63:0] QuatRst       = 64'h4000_0000_0000_0000;

endpackage

>>> hdl/dpwp_front.sv
module dpwp_front #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [11:0]           column_i,
  input  logic [11:0]           row_i,
  input  logic [15:0]           depth_i,
  input  logic [7:0]            blue_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            red_i,
  input  logic [15:0]           cx_i,
  input  logic [15:0]           cy_i,
  input  logic [23:0]           ifx_i,
  input  logic [23:0]           ify_i,
  input  logic [23:0]           ids_i,
  output logic                  out_valid_o,
  output dpwp_pkg::cam_item_t   out_o
);

  // Coordinates keep only their low COORD_BITS bits.
  localparam logic [11:0] CoordMask = 12'((17'd1 << COORD_BITS) - 17'd1);

  // Stage 1: z16, rx, ry. Stage 2: rounded products xc, yc.
  logic                v1_q;
  logic signed [31:0]  rx_q, ry_q;
  logic [31:0]         z1_q;
  logic [7:0]          r1_q, g1_q, b1_q;
  logic                v2_q;
  dpwp_pkg::cam_item_t o_q;

  logic [11:0]           u, v;
  logic [DEPTH_BITS-1:0] d;
  logic [39:0]           zp;
  logic [31:0]           z_d;
  logic signed [17:0]    du, dv;
  logic signed [42:0]    pu, pv;
  logic signed [31:0]    rx_d, ry_d;
  logic signed [64:0]    qx, qy;

  function automatic logic signed [31:0] sat_r(input logic signed [42:0] p);
    logic signed [42:0] s;
    s = (p + 43'sd2048) >>> 12;
    if (s > 43'sd1073741824) return 32'sd1073741824;
    if (s < -43'sd1073741824) return -32'sd1073741824;
    return s[31:0];
  endfunction

  function automatic logic signed [37:0] sat_c(input logic signed [64:0] p);
    logic signed [64:0] s;
    s = (p + 65'sd32768) >>> 16;
    if (s > 65'sd68719476736) return 38'sd68719476736;
    if (s < -65'sd68719476736) return -38'sd68719476736;
    return s[37:0];
  endfunction

  always_comb begin
    u = column_i & CoordMask;
    v = row_i & CoordMask;
    d = depth_i[DEPTH_BITS-1:0];
    zp = 40'(d) * 40'(ids_i);
    z_d = 32'((zp + 40'd128) >> 8);
    du = $signed({2'b00, 16'(u) << 4}) - $signed({2'b00, cx_i});
    dv = $signed({2'b00, 16'(v) << 4}) - $signed({2'b00, cy_i});
    pu = 43'(du) * $signed({19'd0, ifx_i});
    pv = 43'(dv) * $signed({19'd0, ify_i});
    rx_d = sat_r(pu);
    ry_d = sat_r(pv);
    qx = 65'(rx_q) * $signed({33'd0, z1_q});
    qy = 65'(ry_q) * $signed({33'd0, z1_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i && (d != '0);
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_q <= rx_d;
    ry_q <= ry_d;
    z1_q <= z_d;
    r1_q <= red_i;
    g1_q <= green_i;
    b1_q <= blue_i;
    o_q.cam_x <= sat_c(qx);
    o_q.cam_y <= sat_c(qy);
    o_q.cam_z <= 38'(z1_q);
    o_q.red <= r1_q;
    o_q.green <= g1_q;
    o_q.blue <= b1_q;
  end

  assign out_valid_o = v2_q;
  assign out_o = o_q;

endmodule

>>> hdl/dpwp_back.sv
module dpwp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  dpwp_pkg::cam_item_t  in_i,
  input  dpwp_pkg::pose_t      pose_i,
  output logic                 out_valid_o,
  output logic [23:0]          wx_o,
  output logic [23:0]          wy_o,
  output logic [23:0]          wz_o,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o
);

  // Stage 1: nine matrix products. Stage 2: sums, rounding and saturation.
  logic                     v1_q, v2_q;
  logic signed [8:0][63:0]  pr_q;
  logic [7:0]               r_q, g_q, b_q;
  logic signed [2:0][23:0]  w_q;
  logic [7:0]               r2_q, g2_q, b2_q;
  logic signed [2:0][37:0]  cam;
  logic signed [2:0][23:0]  w_d;

  // Elements of a packed array read back unsigned, hence the $signed casts.
  always_comb begin
    cam[0] = in_i.cam_x;
    cam[1] = in_i.cam_y;
    cam[2] = in_i.cam_z;
    for (int i = 0; i < 3; i++) begin
      logic signed [63:0] acc;
      logic signed [63:0] s;
      acc = $signed(pr_q[3*i]) + $signed(pr_q[3*i+1]) + $signed(pr_q[3*i+2])
          + (64'($signed(pose_i.t[i])) <<< 26);
      s = (acc + 64'sd33554432) >>> 26;
      if (s > 64'sd8388607) w_d[i] = 24'sd8388607;
      else if (s < -64'sd8388608) w_d[i] = -24'sd8388608;
      else w_d[i] = s[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      pr_q[i] <= 64'($signed(pose_i.m[i])) * 64'($signed(cam[i%3]));
    end
    r_q <= in_i.red;
    g_q <= in_i.green;
    b_q <= in_i.blue;
    w_q <= w_d;
    r2_q <= r_q;
    g2_q <= g_q;
    b2_q <= b_q;
  end

  assign out_valid_o = v2_q;
  assign wx_o = w_q[0];
  assign wy_o = w_q[1];
  assign wz_o = w_q[2];
  assign red_o = r2_q;
  assign green_o = g2_q;
  assign blue_o = b2_q;

endmodule

>>> hdl/dpwp_fifo.sv
module dpwp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0]          mem_q [DEPTH];
  logic [AW-1:0]             wp_q, rp_q;
  logic [$clog2(DEPTH+1)-1:0] cnt_q;
  logic                      do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (do_pop) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (push_i ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  assign data_o = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

>>> hdl/depth_pixel_to_world_point_top.sv
// Depth pixel to world point.
// Input channel: an item (column, row, depth, blue/green/red) is taken at a
// clock edge with push high and full low. Result channel: while empty
// is low the oldest world point and its color sit on the result ports and
// are taken when pop is high. A pixel with zero depth gives no result.
// One item is accepted per cycle while full is low. A result becomes visible
// once its item has passed two front stages, which compute the camera point,
// and two back stages, which do the pose multiply and the rounding sum.
// Results collect in an eight-entry queue. full rises once four results
// wait, since up to four more items may still be in the stages, so a
// stalled receiver stops the input with no result lost.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i at the
// clock edge; unknown indexes are ignored. The pose matrix is rebuilt from
// the quaternion in a register in the cycle after a write, which falls inside
// the idle time required before writing.
// Reset restores the default camera and identity pose and empties the
// queue.
module depth_pixel_to_world_point_top #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [11:0] column_i,
  input  logic [11:0] row_i,
  input  logic [15:0] depth_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  red_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [23:0] world_x_o,
  output logic [23:0] world_y_o,
  output logic [23:0] world_z_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  input  logic        cfg_we_i,
  input  logic [dpwp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dpwp_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned QDepth = 8;
  localparam int unsigned InFlight = 4;

  logic [15:0] cx_q, cy_q;
  logic [23:0] ifx_q, ify_q, ids_q;
  logic [63:0] quat_q;
  logic [62:0] trans_q;
  dpwp_pkg::pose_t pose_q, pose_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= dpwp_pkg::PrincipalXRst;
      cy_q <= dpwp_pkg::PrincipalYRst;
      ifx_q <= dpwp_pkg::InvFocalXRst;
      ify_q <= dpwp_pkg::InvFocalYRst;
      ids_q <= dpwp_pkg::InvDepthRst;
      quat_q <= dpwp_pkg::QuatRst;
      trans_q <= '0;
    end else if (cfg_we_i) begin
      case (dpwp_pkg::cfg_reg_e'(cfg_idx_i))
        dpwp_pkg::REG_PRINCIPAL_X: cx_q <= cfg_data_i[15:0];
        dpwp_pkg::REG_PRINCIPAL_Y: cy_q <= cfg_data_i[15:0];
        dpwp_pkg::REG_INV_FOCAL_X: ifx_q <= cfg_data_i[23:0];
        dpwp_pkg::REG_INV_FOCAL_Y: ify_q <= cfg_data_i[23:0];
        dpwp_pkg::REG_INV_DEPTH:   ids_q <= cfg_data_i[23:0];
        dpwp_pkg::REG_QUATERNION:  quat_q <= cfg_data_i;
        dpwp_pkg::REG_TRANSLATION: trans_q <= cfg_data_i[62:0];
        default: ;
      endcase
    end
  end

  // Quaternion to rotation matrix, Q.28 products rounded to Q.20.
  function automatic logic signed [25:0] rq(input logic signed [33:0] a);
    logic signed [33:0] s;
    s = (a + 34'sd128) >>> 8;
    return s[25:0];
  endfunction

  always_comb begin
    logic signed [15:0] qx, qy, qz, qw;
    logic signed [33:0] xx, yy, zz, xy, xz, yz, xw, yw, zw, one;
    qx = quat_q[15:0];
    qy = quat_q[31:16];
    qz = quat_q[47:32];
    qw = quat_q[63:48];
    one = 34'sd268435456;
    xx = 34'(qx) * 34'(qx); yy = 34'(qy) * 34'(qy); zz = 34'(qz) * 34'(qz);
    xy = 34'(qx) * 34'(qy); xz = 34'(qx) * 34'(qz); yz = 34'(qy) * 34'(qz);
    xw = 34'(qx) * 34'(qw); yw = 34'(qy) * 34'(qw); zw = 34'(qz) * 34'(qw);
    pose_d.m[0] = rq(one - 2 * (yy + zz));
    pose_d.m[1] = rq(2 * (xy - zw));
    pose_d.m[2] = rq(2 * (xz + yw));
    pose_d.m[3] = rq(2 * (xy + zw));
    pose_d.m[4] = rq(one - 2 * (xx + zz));
    pose_d.m[5] = rq(2 * (yz - xw));
    pose_d.m[6] = rq(2 * (xz - yw));
    pose_d.m[7] = rq(2 * (yz + xw));
    pose_d.m[8] = rq(one - 2 * (xx + yy));
    pose_d.t[0] = trans_q[20:0];
    pose_d.t[1] = trans_q[41:21];
    pose_d.t[2] = trans_q[62:42];
  end

  always_ff @(posedge clk_i) begin
    pose_q <= pose_d;
  end

  logic                accept;
  logic                fr_valid, bk_valid;
  dpwp_pkg::cam_item_t fr_item;
  logic [23:0]         wx, wy, wz;
  logic [7:0]          ro, go, bo;
  logic [95:0]         q_out;
  logic [$clog2(QDepth+1)-1:0] q_cnt;
  logic [$clog2(QDepth+InFlight+1)-1:0] pend;

  assign accept = push && !full;

  dpwp_front #(.COORD_BITS(COORD_BITS), .DEPTH_BITS(DEPTH_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i(accept),
    .column_i, .row_i, .depth_i,
    .blue_i(blue_in_i), .green_i(green_in_i), .red_i(red_in_i),
    .cx_i(cx_q), .cy_i(cy_q), .ifx_i(ifx_q), .ify_i(ify_q), .ids_i(ids_q),
    .out_valid_o(fr_valid), .out_o(fr_item)
  );

  dpwp_back u_back (
    .clk_i, .rst_ni, .in_valid_i(fr_valid), .in_i(fr_item), .pose_i(pose_q),
    .out_valid_o(bk_valid), .wx_o(wx), .wy_o(wy), .wz_o(wz),
    .red_o(ro), .green_o(go), .blue_o(bo)
  );

  dpwp_fifo #(.WIDTH(96), .DEPTH(QDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(bk_valid), .data_i({wx, wy, wz, ro, go, bo}),
    .pop_i(pop), .data_o(q_out), .empty_o(empty), .count_o(q_cnt)
  );

  // Conservative count: every stage slot is assumed occupied, and the item
  // being accepted needs a slot of its own.
  assign pend = $bits(pend)'(q_cnt) + $bits(pend)'(InFlight);
  assign full = (pend >= $bits(pend)'(QDepth));

  assign {world_x_o, world_y_o, world_z_o, red_out_o, green_out_o, blue_out_o} = q_out;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(bk_valid && q_cnt == $bits(q_cnt)'(QDepth)))
    else $error("result queue overflow");
  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && depth_i[DEPTH_BITS-1:0] == '0) |-> ##2 !fr_valid)
    else $error("zero depth item entered the pipe");
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt <= $bits(q_cnt)'(QDepth))
    else $error("result queue count out of range");
  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(q_out))
    else $error("waiting result changed");

endmodule

>>> tb/tb_depth_pixel_to_world_point_top.sv
`timescale 1ns / 1ps

module tb_depth_pixel_to_world_point_top;

  typedef struct {
    logic [11:0] column;
    logic [11:0] row;
    logic [15:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } pixel_t;

  typedef struct {
    logic [23:0] wx;
    logic [23:0] wy;
    logic [23:0] wz;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } point_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [11:0] column_i = '0;
  logic [11:0] row_i = '0;
  logic [15:0] depth_i = '0;
  logic [7:0]  blue_in_i = '0;
  logic [7:0]  green_in_i = '0;
  logic [7:0]  red_in_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [23:0] world_x_o;
  logic [23:0] world_y_o;
  logic [23:0] world_z_o;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  blue_out_o;
  logic        cfg_we_i = 1'b0;
  logic [dpwp_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [dpwp_pkg::CfgDataW-1:0] cfg_data_i = '0;

  depth_pixel_to_world_point_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Camera and pose copy used for prediction.
  logic [15:0] cam_cx, cam_cy;
  logic [23:0] cam_ifx, cam_ify, cam_ids;
  logic [63:0] pose_quat;
  logic [62:0] pose_trans;

  pixel_t pixel_queue[$];
  point_t expected_points[$];
  int     push_idle_pct = 25;
  int     pop_idle_pct = 78;
  int     hold_pop = 0;
  int     errors = 0;
  longint cycle_count = 0;

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic point_t project_pixel(pixel_t p);
    point_t r;
    longint z16, rx, ry, acc;
    longint c[3];
    longint t[3];
    longint m[9];
    longint qx, qy, qz, qw, one;
    one = longint'(1) <<< 28;
    z16 = round_shift(longint'(p.depth) * longint'(cam_ids), 8);
    rx = clamp(round_shift((longint'(p.column) * 16 - longint'(cam_cx)) * longint'(cam_ifx), 12),
               -(longint'(1) <<< 30), longint'(1) <<< 30);
    ry = clamp(round_shift((longint'(p.row) * 16 - longint'(cam_cy)) * longint'(cam_ify), 12),
               -(longint'(1) <<< 30), longint'(1) <<< 30);
    c[0] = clamp(round_shift(rx * z16, 16), -(longint'(1) <<< 36), longint'(1) <<< 36);
    c[1] = clamp(round_shift(ry * z16, 16), -(longint'(1) <<< 36), longint'(1) <<< 36);
    c[2] = z16;
    qx = longint'($signed(pose_quat[15:0]));
    qy = longint'($signed(pose_quat[31:16]));
    qz = longint'($signed(pose_quat[47:32]));
    qw = longint'($signed(pose_quat[63:48]));
    m[0] = one - 2 * (qy * qy + qz * qz);
    m[1] = 2 * (qx * qy - qz * qw);
    m[2] = 2 * (qx * qz + qy * qw);
    m[3] = 2 * (qx * qy + qz * qw);
    m[4] = one - 2 * (qx * qx + qz * qz);
    m[5] = 2 * (qy * qz - qx * qw);
    m[6] = 2 * (qx * qz - qy * qw);
    m[7] = 2 * (qy * qz + qx * qw);
    m[8] = one - 2 * (qx * qx + qy * qy);
    t[0] = longint'($signed(pose_trans[20:0]));
    t[1] = longint'($signed(pose_trans[41:21]));
    t[2] = longint'($signed(pose_trans[62:42]));
    for (int i = 0; i < 3; i++) begin
      acc = round_shift(m[3*i], 8) * c[0] + round_shift(m[3*i+1], 8) * c[1]
          + round_shift(m[3*i+2], 8) * c[2] + t[i] * (longint'(1) <<< 26);
      acc = clamp(round_shift(acc, 26), -(longint'(1) <<< 23), (longint'(1) <<< 23) - 1);
      if (i == 0) r.wx = acc[23:0];
      else if (i == 1) r.wy = acc[23:0];
      else r.wz = acc[23:0];
    end
    r.red = p.red;
    r.green = p.green;
    r.blue = p.blue;
    return r;
  endfunction

  // Input side: the prediction is made when the item is taken.
  always @(posedge clk_i) begin
    if (push && !full) begin
      if (depth_i != 0) expected_points.insert(expected_points.size(),
          project_pixel('{column_i, row_i, depth_i, blue_in_i, green_in_i, red_in_i}));
    end
    if ((!push || !full) && pixel_queue.size() > 0 &&
        $urandom_range(99) >= push_idle_pct) begin
      pixel_t p;
      p = pixel_queue.pop_front();
      push <= 1'b1;
      column_i <= p.column;
      row_i <= p.row;
      depth_i <= p.depth;
      blue_in_i <= p.blue;
      green_in_i <= p.green;
      red_in_i <= p.red;
    end else if (!push || !full) begin
      push <= 1'b0;
    end
  end

  // Result side.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (pop && !empty) begin
      if (expected_points.size() == 0) begin
        $error("unexpected point x=%h", world_x_o);
        errors++;
      end else begin
        point_t e;
        e = expected_points.pop_front();
        if (world_x_o !== e.wx) begin
          $error("world_x exp %h got %h", e.wx, world_x_o); errors++;
        end
        if (world_y_o !== e.wy) begin
          $error("world_y exp %h got %h", e.wy, world_y_o); errors++;
        end
        if (world_z_o !== e.wz) begin
          $error("world_z exp %h got %h", e.wz, world_z_o); errors++;
        end
        if (red_out_o !== e.red) begin
          $error("red_out exp %h got %h", e.red, red_out_o); errors++;
        end
        if (green_out_o !== e.green) begin
          $error("green_out exp %h got %h", e.green, green_out_o); errors++;
        end
        if (blue_out_o !== e.blue) begin
          $error("blue_out exp %h got %h", e.blue, blue_out_o); errors++;
        end
      end
    end
    if (hold_pop > 0) begin
      hold_pop <= hold_pop - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(dpwp_pkg::cfg_reg_e idx, logic [63:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      dpwp_pkg::REG_PRINCIPAL_X: cam_cx = value[15:0];
      dpwp_pkg::REG_PRINCIPAL_Y: cam_cy = value[15:0];
      dpwp_pkg::REG_INV_FOCAL_X: cam_ifx = value[23:0];
      dpwp_pkg::REG_INV_FOCAL_Y: cam_ify = value[23:0];
      dpwp_pkg::REG_INV_DEPTH:   cam_ids = value[23:0];
      dpwp_pkg::REG_QUATERNION:  pose_quat = value;
      dpwp_pkg::REG_TRANSLATION: pose_trans = value[62:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain;
    wait (pixel_queue.size() == 0 && !push && expected_points.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic add_pixel(logic [11:0] u, logic [11:0] v, logic [15:0] d);
    pixel_queue.insert(pixel_queue.size(),
        '{u, v, d, 8'($urandom), 8'($urandom), 8'($urandom)});
  endtask

  // Mostly valid depths; a few zero ones, with small and full-range values mixed.
  task automatic add_random(int n);
    repeat (n) begin
      logic [15:0] d;
      d = ($urandom_range(9) == 0) ? 16'd0 :
          ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000, 1));
      add_pixel(12'($urandom), 12'($urandom), d);
    end
  endtask

  function automatic logic [63:0] unit_quat();
    logic [15:0] a, b;
    a = 16'($signed(16'd11585));
    b = $urandom_range(1) ? a : -a;
    return {a, 16'd0, b, 16'd0};
  endfunction

  initial begin
    cam_cx = dpwp_pkg::PrincipalXRst;
    cam_cy = dpwp_pkg::PrincipalYRst;
    cam_ifx = dpwp_pkg::InvFocalXRst;
    cam_ify = dpwp_pkg::InvFocalYRst;
    cam_ids = dpwp_pkg::InvDepthRst;
    pose_quat = dpwp_pkg::QuatRst;
    pose_trans = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, zero depth, colors at both ends.
    pixel_queue.insert(pixel_queue.size(), '{12'd0, 12'd0, 16'd1, 8'h00, 8'h00, 8'h00});
    pixel_queue.insert(pixel_queue.size(), '{12'hfff, 12'hfff, 16'hffff, 8'hff, 8'hff, 8'hff});
    pixel_queue.insert(pixel_queue.size(), '{12'd325, 12'd253, 16'd0, 8'h12, 8'h34, 8'h56});
    pixel_queue.insert(pixel_queue.size(), '{12'hfff, 12'd0, 16'hffff, 8'ha5, 8'h5a, 8'h0f});
    pixel_queue.insert(pixel_queue.size(), '{12'd0, 12'hfff, 16'd1000, 8'h80, 8'h01, 8'hfe});
    pixel_queue.insert(pixel_queue.size(), '{12'd0, 12'd0, 16'hffff, 8'h01, 8'h80, 8'h7f});
    drain();

    // Extreme camera and non-unit pose, so the outputs saturate.
    write_reg(dpwp_pkg::REG_INV_FOCAL_X, 64'hffffff);
    write_reg(dpwp_pkg::REG_INV_FOCAL_Y, 64'hffffff);
    write_reg(dpwp_pkg::REG_INV_DEPTH, 64'hffffff);
    write_reg(dpwp_pkg::REG_PRINCIPAL_X, 64'hffff);
    write_reg(dpwp_pkg::REG_PRINCIPAL_Y, 64'h0);
    write_reg(dpwp_pkg::REG_QUATERNION, 64'h7fff_8000_7fff_8000);
    write_reg(dpwp_pkg::REG_TRANSLATION, 64'h7fff_ffff_ffff_ffff);
    pixel_queue.insert(pixel_queue.size(), '{12'd0, 12'hfff, 16'hffff, 8'h11, 8'h22, 8'h33});
    pixel_queue.insert(pixel_queue.size(), '{12'hfff, 12'd0, 16'h0001, 8'h44, 8'h55, 8'h66});
    pixel_queue.insert(pixel_queue.size(), '{12'h800, 12'h800, 16'h8000, 8'h77, 8'h88, 8'h99});
    add_random(10);
    drain();

    write_reg(dpwp_pkg::REG_TRANSLATION, {1'b1, 20'd0, 1'b1, 20'd0, 1'b1, 20'd0});
    write_reg(dpwp_pkg::REG_QUATERNION, 64'h0);
    write_reg(dpwp_pkg::REG_INV_DEPTH, 64'h0);
    write_reg(dpwp_pkg::REG_PRINCIPAL_X, 64'h0);
    write_reg(dpwp_pkg::REG_PRINCIPAL_Y, 64'hffff);
    add_random(8);
    drain();

    // Hold the receiver off so the result queue fills and stalls the input.
    write_reg(dpwp_pkg::REG_PRINCIPAL_X, 64'd5208);
    write_reg(dpwp_pkg::REG_PRINCIPAL_Y, 64'd4056);
    write_reg(dpwp_pkg::REG_INV_FOCAL_X, 64'd32389);
    write_reg(dpwp_pkg::REG_INV_FOCAL_Y, 64'd32326);
    write_reg(dpwp_pkg::REG_INV_DEPTH, 64'd16777);
    write_reg(dpwp_pkg::REG_QUATERNION, unit_quat());
    write_reg(dpwp_pkg::REG_TRANSLATION, 64'($urandom) | (64'($urandom) << 32));
    hold_pop = 300;
    add_random(260);
    drain();

    push_idle_pct = 78;
    pop_idle_pct = 25;
    write_reg(dpwp_pkg::REG_QUATERNION, {$urandom, $urandom});
    write_reg(dpwp_pkg::REG_INV_FOCAL_X, 64'($urandom_range(65535)));
    write_reg(dpwp_pkg::REG_INV_FOCAL_Y, 64'($urandom));
    write_reg(dpwp_pkg::REG_INV_DEPTH, 64'($urandom_range(100000)));
    write_reg(dpwp_pkg::REG_PRINCIPAL_X, 64'($urandom));
    write_reg(dpwp_pkg::REG_PRINCIPAL_Y, 64'($urandom));
    write_reg(dpwp_pkg::REG_TRANSLATION, 64'($urandom) | (64'($urandom) << 32));
    add_random(260);
    drain();

    push_idle_pct = 0;
    pop_idle_pct = 0;
    write_reg(dpwp_pkg::REG_QUATERNION, dpwp_pkg::QuatRst);
    write_reg(dpwp_pkg::REG_TRANSLATION, 64'h0);
    add_random(260);
    drain();

    if (errors == 0 && expected_points.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/dpwp_pkg.sv
hdl/dpwp_front.sv
hdl/dpwp_back.sv
hdl/dpwp_fifo.sv
hdl/depth_pixel_to_world_point_top.sv
tb/tb_depth_pixel_to_world_point_top.sv
